>>> src/sdeq_pkg.sv
package sdeq_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP_MIN = 2'd1,
    OP_POP_MAX = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                     insert;
    logic                     pop_min;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

>>> src/sdeq_cell.sv
module sdeq_cell (
  input  logic                                 clk,
  input  sdeq_pkg::cell_ctrl_t                 ctrl,
  input  logic                                 occupied,
  input  logic                                 left_lt,
  input  logic signed [sdeq_pkg::ValueW-1:0]   left_entry,
  input  logic signed [sdeq_pkg::ValueW-1:0]   right_entry,
  output logic signed [sdeq_pkg::ValueW-1:0]   entry,
  output logic                                 lt
);

  logic signed [sdeq_pkg::ValueW-1:0] entry_next;

  // lt marks occupied cells that stay ahead of the new value
  assign lt = occupied && (entry < ctrl.value);

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (!lt) begin
        entry_next = left_lt ? ctrl.value : left_entry;
      end
    end else if (ctrl.pop_min) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

>>> src/sorted_double_ended_queue.sv
// Sorted double-ended queue, one entry per cell in a shifting chain.
// Results are registered: a result appears in the cycle after its item is accepted.
// Throughput: one item per cycle while item_stall is low; every cell compares and shifts in parallel.
// item_stall rises only while a result is held by result_stall.
// Reset (rst, synchronous) empties the queue and drops any pending result;
// entry contents are not cleared.
module sorted_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        item_valid,
  output logic                                        item_stall,
  input  logic [1:0]                                  operation,
  input  logic signed [sdeq_pkg::ValueW-1:0]          value,
  output logic                                        result_valid,
  input  logic                                        result_stall,
  output logic signed [sdeq_pkg::ValueW-1:0]          removed_value,
  output logic [1:0]                                  status,
  output logic [$clog2(DEPTH+1)-1:0]                  entry_count
);

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  logic [CountW-1:0]                  count;
  logic [CountW-1:0]                  count_next;
  logic                               accept;
  logic                               empty;
  logic                               full;
  logic [DEPTH-1:0]                   occ;
  logic [DEPTH-1:0]                   lt;
  logic signed [sdeq_pkg::ValueW-1:0] entries [DEPTH];
  logic signed [sdeq_pkg::ValueW-1:0] tail_value;
  logic signed [sdeq_pkg::ValueW-1:0] removed_next;
  sdeq_pkg::status_t                  status_next;
  sdeq_pkg::cell_ctrl_t               ctrl;

  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign empty      = (count == '0);
  assign full       = (count == CountW'(DEPTH));

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (occ[i] && ((i == DEPTH - 1) || !occ[(i + 1) % DEPTH])) begin
        tail_value = tail_value | entries[i];
      end
    end
  end

  always_comb begin
    ctrl.insert  = 1'b0;
    ctrl.pop_min = 1'b0;
    ctrl.value   = value;
    count_next   = count;
    removed_next = '0;
    status_next  = sdeq_pkg::ST_OK;
    case (sdeq_pkg::op_t'(operation))
      sdeq_pkg::OP_INSERT: begin
        if (full) begin
          status_next = sdeq_pkg::ST_FULL;
        end else begin
          ctrl.insert = accept;
          count_next  = count + CountW'(1);
        end
      end
      sdeq_pkg::OP_POP_MIN: begin
        if (empty) begin
          status_next = sdeq_pkg::ST_EMPTY;
        end else begin
          ctrl.pop_min = accept;
          removed_next = entries[0];
          count_next   = count - CountW'(1);
        end
      end
      sdeq_pkg::OP_POP_MAX: begin
        if (empty) begin
          status_next = sdeq_pkg::ST_EMPTY;
        end else begin
          removed_next = tail_value;
          count_next   = count - CountW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                               left_lt;
    logic signed [sdeq_pkg::ValueW-1:0] left_entry;
    logic signed [sdeq_pkg::ValueW-1:0] right_entry;

    assign occ[g] = (count > CountW'(g));

    if (g == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = entries[0];
    end else begin : g_body
      assign left_lt    = lt[g-1];
      assign left_entry = entries[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_entry = entries[g];
    end else begin : g_inner
      assign right_entry = entries[g+1];
    end

    sdeq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occ[g]),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[g]),
      .lt          (lt[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      removed_value <= removed_next;
      status        <= status_next;
      entry_count   <= count_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CountW'(DEPTH))
    else $error("count above depth");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == sdeq_pkg::ST_FULL) |-> entry_count == CountW'(DEPTH))
    else $error("full status with room left");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == sdeq_pkg::ST_EMPTY) |-> entry_count == '0)
    else $error("empty status with entries stored");

  assert property (@(posedge clk) disable iff (rst)
    !accept |=> count == $past(count))
    else $error("count moved without an item");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned Depth = 16;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic signed [sdeq_pkg::ValueW-1:0] removed_value;
    sdeq_pkg::status_t                  status;
    logic [CountW-1:0]                  entry_count;
  } reply_t;

  class deque_scoreboard;
    logic signed [sdeq_pkg::ValueW-1:0] shadow [Depth];
    int unsigned                        occupied;
    reply_t                             replies [$];
    int unsigned                        mismatches;

    function new();
      occupied = 0;
      mismatches = 0;
    endfunction

    function void note_item(sdeq_pkg::op_t op, logic signed [sdeq_pkg::ValueW-1:0] val);
      reply_t      r;
      int unsigned pos;
      int unsigned i;
      r.removed_value = '0;
      r.status = sdeq_pkg::ST_OK;
      case (op)
        sdeq_pkg::OP_INSERT: begin
          if (occupied >= Depth) begin
            r.status = sdeq_pkg::ST_FULL;
          end else begin
            pos = 0;
            while (pos < occupied && shadow[pos] < val) pos++;
            for (i = occupied; i > pos; i--) shadow[i] = shadow[i-1];
            shadow[pos] = val;
            occupied++;
          end
        end
        sdeq_pkg::OP_POP_MIN: begin
          if (occupied == 0) begin
            r.status = sdeq_pkg::ST_EMPTY;
          end else begin
            r.removed_value = shadow[0];
            for (i = 1; i < occupied; i++) shadow[i-1] = shadow[i];
            occupied--;
          end
        end
        sdeq_pkg::OP_POP_MAX: begin
          if (occupied == 0) begin
            r.status = sdeq_pkg::ST_EMPTY;
          end else begin
            r.removed_value = shadow[occupied-1];
            occupied--;
          end
        end
        default: begin
        end
      endcase
      r.entry_count = occupied[CountW-1:0];
      replies.push_back(r);
    endfunction

    function void check_result(logic signed [sdeq_pkg::ValueW-1:0] got_value,
                               logic [1:0] got_status,
                               logic [CountW-1:0] got_count);
      reply_t want;
      if (replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("mismatch: unexpected result value %0d status %0d count %0d",
                   got_value, got_status, got_count);
        return;
      end
      want = replies.pop_front();
      if (got_value !== want.removed_value || got_status !== want.status ||
          got_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display({"mismatch: expected value %0d status %0d count %0d, ",
                    "got value %0d status %0d count %0d"},
                   want.removed_value, want.status, want.entry_count,
                   got_value, got_status, got_count);
      end
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               item_valid = 1'b0;
  logic                               item_stall;
  logic [1:0]                         operation = 2'b00;
  logic signed [sdeq_pkg::ValueW-1:0] value = '0;
  logic                               result_valid;
  logic                               result_stall = 1'b0;
  logic signed [sdeq_pkg::ValueW-1:0] removed_value;
  logic [1:0]                         status;
  logic [CountW-1:0]                  entry_count;

  logic                               hold_off = 1'b0;
  int unsigned                        send_idle_pct = 27;
  int unsigned                        recv_idle_pct = 82;
  int unsigned                        items_accepted = 0;
  int unsigned                        cycle_count = 0;
  deque_scoreboard                    tracker = new();

  sorted_double_ended_queue #(.DEPTH(Depth)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .value(value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .removed_value(removed_value),
    .status(status),
    .entry_count(entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(input sdeq_pkg::op_t op,
                           input logic signed [sdeq_pkg::ValueW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    value <= val;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tracker.note_item(op, val);
    items_accepted++;
  endtask

  task automatic run_directed();
    send_item(sdeq_pkg::OP_POP_MIN, 32'sd0);
    send_item(sdeq_pkg::OP_POP_MAX, 32'sd0);
    send_item(sdeq_pkg::OP_NONE, 32'sh5A5A_A5A5);
    send_item(sdeq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    send_item(sdeq_pkg::OP_INSERT, 32'sh8000_0000);
    send_item(sdeq_pkg::OP_INSERT, 32'sd0);
    send_item(sdeq_pkg::OP_INSERT, -32'sd1);
    send_item(sdeq_pkg::OP_INSERT, 32'sd1);
    send_item(sdeq_pkg::OP_POP_MIN, 32'sd0);
    send_item(sdeq_pkg::OP_POP_MAX, 32'sd0);
    repeat (13) send_item(sdeq_pkg::OP_INSERT, $urandom_range(6) - 3);
    send_item(sdeq_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    send_item(sdeq_pkg::OP_NONE, 32'shFFFF_FFFF);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned                        insert_pct;
    int unsigned                        burst_left;
    int unsigned                        roll;
    logic signed [sdeq_pkg::ValueW-1:0] v;
    sdeq_pkg::op_t                      op;
    burst_left = 0;
    insert_pct = 50;
    repeat (n) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0: insert_pct = 80;
          1: insert_pct = 20;
          default: insert_pct = 50;
        endcase
      end
      burst_left--;
      if ($urandom_range(99) < 4) op = sdeq_pkg::OP_NONE;
      else if ($urandom_range(99) < insert_pct) op = sdeq_pkg::OP_INSERT;
      else if ($urandom_range(1) == 1) op = sdeq_pkg::OP_POP_MIN;
      else op = sdeq_pkg::OP_POP_MAX;
      roll = $urandom_range(99);
      if (roll < 40) v = $urandom_range(16) - 8;
      else if (roll < 50) v = ($urandom_range(1) == 1 ? 32'h7FFF_FFFF : 32'h8000_0000)
                              ^ $urandom_range(3);
      else v = $urandom;
      send_item(op, v);
    end
  endtask

  initial begin
    while (rst) @(posedge clk);
    forever begin
      result_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
      @(posedge clk);
      if (result_valid && !result_stall)
        tracker.check_result(removed_value, status, entry_count);
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    while (items_accepted < 150) @(posedge clk);
    hold_off <= 1'b1;
    repeat (90) @(posedge clk);
    hold_off <= 1'b0;
    while (items_accepted < 600) @(posedge clk);
    hold_off <= 1'b1;
    repeat (90) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(320);
    send_idle_pct = 82;
    recv_idle_pct = 27;
    run_random(320);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(310);
    item_valid <= 1'b0;
    while (tracker.replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
src/sdeq_pkg.sv
src/sdeq_cell.sv
src/sorted_double_ended_queue.sv
bench/testbench.sv
